// ===== design/suffix_automaton_refrain_top_defines.svh =====
// Assertion macros for the suffix automaton refrain block.
`ifndef SUFFIX_AUTOMATON_REFRAIN_TOP_DEFINES_SVH
`define SUFFIX_AUTOMATON_REFRAIN_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sar assertion failed");
`define SAR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sar assertion failed");
`else
`define SAR_ASSERT_IMP(lbl, ante, cons)
`define SAR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/sar_pkg.sv =====
// Package: sizes, codes and transaction types of the suffix automaton refrain block.
`default_nettype none
package sar_pkg;
    localparam int MAX_LEN    = 1024;
    localparam int MAX_STATES = 2048;
    localparam int ALPHABET   = 10;
    localparam int ST_W       = $clog2(MAX_STATES);
    localparam int CNT_W      = ST_W + 1;
    localparam int LEN_W      = $clog2(MAX_LEN) + 1;
    localparam int POS_W      = $clog2(MAX_LEN);
    localparam int SYM_W      = 4;
    localparam int TR_DEPTH   = MAX_STATES * 16;
    localparam int TR_AW      = ST_W + SYM_W;
    localparam int BK_DEPTH   = MAX_LEN + 2;
    localparam int BK_AW      = $clog2(BK_DEPTH);
    localparam int SCORE_W    = 21;
    localparam int PROD_W     = 2 * LEN_W;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_CAP   = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [SYM_W-1:0] symbol;
        logic [POS_W-1:0] read_pos;
    } in_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] best_score;
        logic [LEN_W-1:0]   best_length;
        logic [SYM_W-1:0]   answer_symbol;
        logic [1:0]         status;
    } out_item_t;
endpackage
`default_nettype wire

// ===== design/sar_ifs.sv =====
// Interfaces: request and result channels of the suffix automaton refrain block.
`default_nettype none
interface sar_in_if;
    logic              valid;
    logic              ready;
    sar_pkg::in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface sar_out_if;
    logic               valid;
    logic               ready;
    sar_pkg::out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

// ===== design/suffix_automaton_refrain_top.sv =====
// Top level: online suffix automaton with best occurrences-times-length search.
//
//  channel  | dir | payload                                          | handshake
//  ---------+-----+--------------------------------------------------+------------
//  in_ch    | in  | op, symbol, read_pos                             | valid/ready
//  out_ch   | out | best_score, best_length, answer_symbol, status   | valid/ready
//
// After reset the root row is cleared; in_ch.ready stays low meanwhile.
// An append walks suffix links; a solid transition ends it, while a clone copies the row
// of t and redirects transitions. Finish marks terminal states, builds the length
// histogram, sums occurrences and writes the answer string. Reads fetch one answer
// symbol; rejected transactions go straight to the result stage. One transaction is in
// flight; a pending result waits in the output register and stalls only the next completion.
`default_nettype none
`include "suffix_automaton_refrain_top_defines.svh"
module suffix_automaton_refrain_top (
    input  wire logic clk,
    input  wire logic rst_n,
    sar_in_if.sink    in_ch,
    sar_out_if.source out_ch
);
    import sar_pkg::*;

    typedef enum logic [5:0] {
        S_INIT, S_IDLE, S_RD, S_DONE,
        S_AP_INIT, S_AP_CLR, S_AP_RD, S_AP_T, S_AP_LNK, S_AP_PT,
        S_AP_CL1, S_AP_CL2, S_AP_CPR, S_AP_CPW, S_AP_RR, S_AP_RT,
        S_EV_TM, S_EV_TL, S_EV_BC, S_EV_H1, S_EV_H2, S_EV_H3,
        S_EV_P1, S_EV_P2, S_EV_O1, S_EV_O2, S_EV_O3,
        S_EV_S1, S_EV_S2, S_EV_S3, S_EV_S4, S_EV_S5,
        S_EV_B1, S_EV_B2, S_EV_B3, S_EV_W1, S_EV_W2
    } state_t;

    // Memories: transitions, per-state fields, sort scratch, answer string.
    logic [ST_W-1:0]  tr_mem   [TR_DEPTH];
    logic [ST_W-1:0]  lnk_mem  [MAX_STATES];
    logic [ST_W-1:0]  par_mem  [MAX_STATES];
    logic [LEN_W-1:0] len_mem  [MAX_STATES];
    logic [SYM_W-1:0] sym_mem  [MAX_STATES];
    logic             term_mem [MAX_STATES];
    logic [ST_W-1:0]  occ_mem  [MAX_STATES];
    logic [CNT_W-1:0] bk_mem   [BK_DEPTH];
    logic [ST_W-1:0]  ord_mem  [MAX_STATES];
    logic [SYM_W-1:0] ans_mem  [MAX_LEN];

    logic             tr_we;
    logic [TR_AW-1:0] tr_waddr, tr_raddr;
    logic [ST_W-1:0]  tr_wdata, tr_rdata;

    // Per-state memories share one read and one write address.
    logic [ST_W-1:0]  st_raddr, st_waddr;
    logic             lnk_we, par_we, len_we, sym_we, term_we, occ_we;
    logic [ST_W-1:0]  lnk_wdata, par_wdata, occ_wdata;
    logic [LEN_W-1:0] len_wdata;
    logic [SYM_W-1:0] sym_wdata;
    logic             term_wdata;
    logic [ST_W-1:0]  lnk_rdata, par_rdata, occ_rdata;
    logic [LEN_W-1:0] len_rdata;
    logic [SYM_W-1:0] sym_rdata;
    logic             term_rdata;

    logic             bk_we;
    logic [BK_AW-1:0] bk_waddr, bk_raddr;
    logic [CNT_W-1:0] bk_wdata, bk_rdata;

    logic             ord_we;
    logic [ST_W-1:0]  ord_waddr, ord_raddr, ord_wdata, ord_rdata;

    logic             ans_we;
    logic [POS_W-1:0] ans_waddr, ans_raddr;
    logic [SYM_W-1:0] ans_wdata, ans_rdata;

    // Sequencer registers.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ST_W-1:0]   last_reg, last_next;
    logic [LEN_W-1:0]  lastlen_reg, lastlen_next;
    logic              fin_reg, fin_next;
    logic [ST_W-1:0]   a_reg, a_next;
    logic [ST_W-1:0]   b_reg, b_next;
    logic [ST_W-1:0]   t_reg, t_next;
    logic [ST_W-1:0]   d_reg, d_next;
    logic [ST_W-1:0]   s_reg, s_next;
    logic [SYM_W-1:0]  c_reg, c_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [LEN_W-1:0]  lena_reg, lena_next;
    logic [BK_AW-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [BK_AW-1:0]  bidx_reg, bidx_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [LEN_W-1:0]  lenc_reg, lenc_next;
    logic [PROD_W-1:0] bscore_reg, bscore_next;
    logic [ST_W-1:0]   bstate_reg, bstate_next;
    logic [LEN_W-1:0]  blen_reg, blen_next;
    logic [1:0]        pstat_reg, pstat_next;
    logic [SYM_W-1:0]  pans_reg, pans_next;
    logic              ov_reg, ov_next;
    out_item_t         out_reg, out_next;

    always_ff @(posedge clk)
    begin
        if (tr_we)
        begin
            tr_mem[tr_waddr] <= tr_wdata;
        end
        tr_rdata <= tr_mem[tr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lnk_we)
        begin
            lnk_mem[st_waddr] <= lnk_wdata;
        end
        if (par_we)
        begin
            par_mem[st_waddr] <= par_wdata;
        end
        if (len_we)
        begin
            len_mem[st_waddr] <= len_wdata;
        end
        if (sym_we)
        begin
            sym_mem[st_waddr] <= sym_wdata;
        end
        if (term_we)
        begin
            term_mem[st_waddr] <= term_wdata;
        end
        if (occ_we)
        begin
            occ_mem[st_waddr] <= occ_wdata;
        end
        lnk_rdata  <= lnk_mem[st_raddr];
        par_rdata  <= par_mem[st_raddr];
        len_rdata  <= len_mem[st_raddr];
        sym_rdata  <= sym_mem[st_raddr];
        term_rdata <= term_mem[st_raddr];
        occ_rdata  <= occ_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bk_we)
        begin
            bk_mem[bk_waddr] <= bk_wdata;
        end
        bk_rdata <= bk_mem[bk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        ord_rdata <= ord_mem[ord_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ans_we)
        begin
            ans_mem[ans_waddr] <= ans_wdata;
        end
        ans_rdata <= ans_mem[ans_raddr];
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = ov_reg;
    assign out_ch.item = out_reg;

    always_comb
    begin
        logic [CNT_W-1:0] sum;
        logic [ST_W-1:0]  acc_add;

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        lastlen_next = lastlen_reg;
        fin_next     = fin_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        t_next       = t_reg;
        d_next       = d_reg;
        s_next       = s_reg;
        c_next       = c_reg;
        sym_next     = sym_reg;
        lena_next    = lena_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        bidx_next    = bidx_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        lenc_next    = lenc_reg;
        bscore_next  = bscore_reg;
        bstate_next  = bstate_reg;
        blen_next    = blen_reg;
        pstat_next   = pstat_reg;
        pans_next    = pans_reg;
        ov_next      = ov_reg;
        out_next     = out_reg;
        sum          = '0;
        acc_add      = '0;

        tr_we = 1'b0; tr_waddr = '0; tr_raddr = '0; tr_wdata = '0;
        st_raddr = '0; st_waddr = '0;
        lnk_we = 1'b0; par_we = 1'b0; len_we = 1'b0;
        sym_we = 1'b0; term_we = 1'b0; occ_we = 1'b0;
        lnk_wdata = '0; par_wdata = '0; occ_wdata = '0;
        len_wdata = '0; sym_wdata = '0; term_wdata = 1'b0;
        bk_we = 1'b0; bk_waddr = '0; bk_raddr = '0; bk_wdata = '0;
        ord_we = 1'b0; ord_waddr = '0; ord_raddr = '0; ord_wdata = '0;
        ans_we = 1'b0; ans_waddr = '0; ans_raddr = '0; ans_wdata = '0;

        // Drop the result once the sink takes it.
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                // Clear the root row and the root's fields.
                tr_we    = 1'b1;
                tr_waddr = {ST_W'(0), k_reg[SYM_W-1:0]};
                lnk_we = 1'b1; par_we = 1'b1; len_we = 1'b1;
                sym_we = 1'b1; term_we = 1'b1;
                if (k_reg == BK_AW'(ALPHABET - 1))
                begin
                    k_next     = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    pans_next  = '0;
                    pstat_next = STAT_OK;
                    state_next = S_DONE;
                    unique case (in_ch.item.op)
                        OP_APPEND:
                        begin
                            if (fin_reg || in_ch.item.symbol == '0 ||
                                in_ch.item.symbol > SYM_W'(ALPHABET))
                            begin
                                pstat_next = STAT_ORDER;
                            end
                            else if (lastlen_reg >= LEN_W'(MAX_LEN) ||
                                     cnt_reg + CNT_W'(2) > CNT_W'(MAX_STATES))
                            begin
                                pstat_next = STAT_CAP;
                            end
                            else
                            begin
                                c_next     = in_ch.item.symbol - 1'b1;
                                sym_next   = in_ch.item.symbol;
                                state_next = S_AP_INIT;
                            end
                        end
                        OP_FINISH:
                        begin
                            if (fin_reg)
                            begin
                                pstat_next = STAT_ORDER;
                            end
                            else
                            begin
                                a_next     = last_reg;
                                state_next = S_EV_TM;
                            end
                        end
                        OP_READ:
                        begin
                            if (!fin_reg)
                            begin
                                pstat_next = STAT_ORDER;
                            end
                            else if ({1'b0, in_ch.item.read_pos} < blen_reg)
                            begin
                                ans_raddr  = in_ch.item.read_pos;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            pstat_next = STAT_ORDER;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                pans_next  = ans_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next                = 1'b1;
                    out_next.best_score    = fin_reg ? bscore_reg[SCORE_W-1:0] : '0;
                    out_next.best_length   = fin_reg ? blen_reg : '0;
                    out_next.answer_symbol = pans_reg;
                    out_next.status        = pstat_reg;
                    state_next             = S_IDLE;
                end
            end

            // ---------------- append ----------------
            S_AP_INIT:
            begin
                b_next       = cnt_reg[ST_W-1:0];
                a_next       = last_reg;
                cnt_next     = cnt_reg + 1'b1;
                last_next    = cnt_reg[ST_W-1:0];
                lastlen_next = lastlen_reg + 1'b1;
                st_waddr     = cnt_reg[ST_W-1:0];
                len_we = 1'b1; len_wdata = lastlen_reg + 1'b1;
                par_we = 1'b1; par_wdata = last_reg;
                sym_we = 1'b1; sym_wdata = sym_reg;
                lnk_we = 1'b1; term_we = 1'b1;
                k_next       = '0;
                state_next   = S_AP_CLR;
            end
            S_AP_CLR:
            begin
                tr_we    = 1'b1;
                tr_waddr = {b_reg, k_reg[SYM_W-1:0]};
                if (k_reg == BK_AW'(ALPHABET - 1))
                begin
                    state_next = S_AP_RD;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_AP_RD:
            begin
                tr_raddr   = {a_reg, c_reg};
                st_raddr   = a_reg;
                state_next = S_AP_T;
            end
            S_AP_T:
            begin
                lena_next = len_rdata;
                if (tr_rdata == '0)
                begin
                    tr_we    = 1'b1;
                    tr_waddr = {a_reg, c_reg};
                    tr_wdata = b_reg;
                    st_raddr = a_reg;
                    state_next = (a_reg == '0) ? S_DONE : S_AP_LNK;
                end
                else
                begin
                    t_next     = tr_rdata;
                    st_raddr   = tr_rdata;
                    state_next = S_AP_PT;
                end
            end
            S_AP_LNK:
            begin
                a_next     = lnk_rdata;
                state_next = S_AP_RD;
            end
            S_AP_PT:
            begin
                if (par_rdata == a_reg)
                begin
                    st_waddr   = b_reg;
                    lnk_we     = 1'b1;
                    lnk_wdata  = t_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    // Clone t into a fresh state d.
                    d_next   = cnt_reg[ST_W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                    st_waddr = cnt_reg[ST_W-1:0];
                    len_we = 1'b1; len_wdata = lena_reg + 1'b1;
                    sym_we = 1'b1; sym_wdata = sym_rdata;
                    lnk_we = 1'b1; lnk_wdata = lnk_rdata;
                    par_we = 1'b1; par_wdata = a_reg;
                    term_we    = 1'b1;
                    state_next = S_AP_CL1;
                end
            end
            S_AP_CL1:
            begin
                st_waddr   = t_reg;
                lnk_we     = 1'b1;
                lnk_wdata  = d_reg;
                state_next = S_AP_CL2;
            end
            S_AP_CL2:
            begin
                st_waddr   = b_reg;
                lnk_we     = 1'b1;
                lnk_wdata  = d_reg;
                k_next     = '0;
                state_next = S_AP_CPR;
            end
            S_AP_CPR:
            begin
                tr_raddr   = {t_reg, k_reg[SYM_W-1:0]};
                state_next = S_AP_CPW;
            end
            S_AP_CPW:
            begin
                tr_we    = 1'b1;
                tr_waddr = {d_reg, k_reg[SYM_W-1:0]};
                tr_wdata = tr_rdata;
                if (k_reg == BK_AW'(ALPHABET - 1))
                begin
                    state_next = S_AP_RR;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_AP_CPR;
                end
            end
            S_AP_RR:
            begin
                tr_raddr   = {a_reg, c_reg};
                st_raddr   = a_reg;
                state_next = S_AP_RT;
            end
            S_AP_RT:
            begin
                if (tr_rdata != t_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    tr_we    = 1'b1;
                    tr_waddr = {a_reg, c_reg};
                    tr_wdata = d_reg;
                    if (a_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        a_next     = lnk_rdata;
                        state_next = S_AP_RR;
                    end
                end
            end

            // ---------------- finish ----------------
            S_EV_TM:
            begin
                st_waddr   = a_reg;
                term_we    = 1'b1;
                term_wdata = 1'b1;
                st_raddr   = a_reg;
                k_next     = '0;
                state_next = (a_reg == '0) ? S_EV_BC : S_EV_TL;
            end
            S_EV_TL:
            begin
                a_next     = lnk_rdata;
                state_next = S_EV_TM;
            end
            S_EV_BC:
            begin
                bk_we    = 1'b1;
                bk_waddr = k_reg;
                if (k_reg == BK_AW'(BK_DEPTH - 1))
                begin
                    i_next     = '0;
                    state_next = S_EV_H1;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_EV_H1:
            begin
                st_raddr   = i_reg[ST_W-1:0];
                state_next = S_EV_H2;
            end
            S_EV_H2:
            begin
                bidx_next  = BK_AW'(len_rdata) + 1'b1;
                bk_raddr   = BK_AW'(len_rdata) + 1'b1;
                state_next = S_EV_H3;
            end
            S_EV_H3:
            begin
                bk_we    = 1'b1;
                bk_waddr = bidx_reg;
                bk_wdata = bk_rdata + 1'b1;
                i_next   = i_reg + 1'b1;
                if (i_reg + 1'b1 == cnt_reg)
                begin
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = S_EV_P1;
                end
                else
                begin
                    state_next = S_EV_H1;
                end
            end
            S_EV_P1:
            begin
                bk_raddr   = k_reg;
                state_next = S_EV_P2;
            end
            S_EV_P2:
            begin
                sum      = acc_reg + bk_rdata;
                acc_next = sum;
                bk_we    = 1'b1;
                bk_waddr = k_reg;
                bk_wdata = sum;
                if (k_reg == BK_AW'(BK_DEPTH - 1))
                begin
                    i_next     = '0;
                    state_next = S_EV_O1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_EV_P1;
                end
            end
            S_EV_O1:
            begin
                st_raddr   = i_reg[ST_W-1:0];
                state_next = S_EV_O2;
            end
            S_EV_O2:
            begin
                bidx_next  = BK_AW'(len_rdata);
                bk_raddr   = BK_AW'(len_rdata);
                state_next = S_EV_O3;
            end
            S_EV_O3:
            begin
                ord_we    = 1'b1;
                ord_waddr = bk_rdata[ST_W-1:0];
                ord_wdata = i_reg[ST_W-1:0];
                bk_we     = 1'b1;
                bk_waddr  = bidx_reg;
                bk_wdata  = bk_rdata + 1'b1;
                i_next    = i_reg + 1'b1;
                if (i_reg + 1'b1 == cnt_reg)
                begin
                    i_next     = cnt_reg;
                    state_next = S_EV_S1;
                end
                else
                begin
                    state_next = S_EV_O1;
                end
            end
            S_EV_S1:
            begin
                // Longest states first, so every target is already summed.
                ord_raddr  = i_reg[ST_W-1:0] - 1'b1;
                state_next = S_EV_S2;
            end
            S_EV_S2:
            begin
                s_next     = ord_rdata;
                st_raddr   = ord_rdata;
                k_next     = '0;
                state_next = S_EV_S3;
            end
            S_EV_S3:
            begin
                if (k_reg == '0)
                begin
                    acc_next = CNT_W'(term_rdata);
                end
                tr_raddr   = {s_reg, k_reg[SYM_W-1:0]};
                state_next = S_EV_S4;
            end
            S_EV_S4:
            begin
                t_next     = tr_rdata;
                st_raddr   = tr_rdata;
                state_next = S_EV_S5;
            end
            S_EV_S5:
            begin
                acc_add  = (t_reg != '0) ? occ_rdata : '0;
                sum      = acc_reg + CNT_W'(acc_add);
                acc_next = sum;
                if (k_reg == BK_AW'(ALPHABET - 1))
                begin
                    st_waddr  = s_reg;
                    occ_we    = 1'b1;
                    occ_wdata = sum[ST_W-1:0];
                    i_next    = i_reg - 1'b1;
                    if (i_reg == CNT_W'(1))
                    begin
                        i_next      = '0;
                        bscore_next = '0;
                        bstate_next = '0;
                        blen_next   = '0;
                        state_next  = S_EV_B1;
                    end
                    else
                    begin
                        state_next = S_EV_S1;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_EV_S3;
                end
            end
            S_EV_B1:
            begin
                st_raddr   = i_reg[ST_W-1:0];
                state_next = S_EV_B2;
            end
            S_EV_B2:
            begin
                prod_next  = PROD_W'(occ_rdata) * PROD_W'(len_rdata);
                lenc_next  = len_rdata;
                state_next = S_EV_B3;
            end
            S_EV_B3:
            begin
                a_next = bstate_reg;
                if (prod_reg > bscore_reg)
                begin
                    bscore_next = prod_reg;
                    bstate_next = i_reg[ST_W-1:0];
                    blen_next   = lenc_reg;
                    a_next      = i_reg[ST_W-1:0];
                end
                i_next = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 == cnt_reg) ? S_EV_W1 : S_EV_B1;
            end
            S_EV_W1:
            begin
                if (a_reg == '0)
                begin
                    fin_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    st_raddr   = a_reg;
                    state_next = S_EV_W2;
                end
            end
            S_EV_W2:
            begin
                ans_we     = (len_rdata != '0);
                ans_waddr  = POS_W'(len_rdata - 1'b1);
                ans_wdata  = sym_rdata;
                a_next     = par_rdata;
                state_next = S_EV_W1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            cnt_reg     <= CNT_W'(1);
            last_reg    <= '0;
            lastlen_reg <= '0;
            fin_reg     <= 1'b0;
            k_reg       <= '0;
            i_reg       <= '0;
            bscore_reg  <= '0;
            bstate_reg  <= '0;
            blen_reg    <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            lastlen_reg <= lastlen_next;
            fin_reg     <= fin_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            bscore_reg  <= bscore_next;
            bstate_reg  <= bstate_next;
            blen_reg    <= blen_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        t_reg     <= t_next;
        d_reg     <= d_next;
        s_reg     <= s_next;
        c_reg     <= c_next;
        sym_reg   <= sym_next;
        lena_reg  <= lena_next;
        bidx_reg  <= bidx_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        lenc_reg  <= lenc_next;
        pstat_reg <= pstat_next;
        pans_reg  <= pans_next;
        out_reg   <= out_next;
    end

    // State count never passes capacity.
    `SAR_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= CNT_W'(MAX_STATES))
    // Finish completes straight into the result stage.
    `SAR_ASSERT_IMP(a_fin_done, $rose(fin_reg), state_reg == S_DONE)
    // No score is reported before finish.
    `SAR_ASSERT_IMP(a_no_score, ov_reg && !fin_reg, out_reg.best_score == '0 && out_reg.best_length == '0)
endmodule
`default_nettype wire
